// ----- src/lirl_pkg.sv -----
// Shared constants for the longest increasing run length block.
// No dependencies.
package lirl_pkg;

    localparam int MAX_ITEMS_DEF  = 1024;  // cells in the tail chain
    localparam int VALUE_BITS_DEF = 16;    // value bits that take part in compares

    localparam int BOX_W     = 16;  // box_size field
    localparam int RUN_W     = 11;  // run_length field
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

endpackage

// ----- src/longest_increasing_run_length.sv -----
// Top level: longest strictly increasing subsequence length over a stream.
// Depends on lirl_pkg and lirl_cell.
//
//  channel  dir  fields
//  s_*      in   tdata: box_size[15:0]; tlast: is_last
//  m_*      out  tdata: run_length[10:0], zeros[15:11]; tuser: overflow
//
// Values enter one per cycle and ripple down a chain of MAX_ITEMS cells, one
// cell per cycle; each cell keeps the smallest tail for one run length.
// After the tlast transfer, s_tready drops while the chain drains: the result
// is loaded once the drain counter passes the fill count, then the chain is
// empty again. A stalled m_tready holds the result and, if a second sequence
// ends meanwhile, holds that drain too. Reset clears counts and flags only.
module longest_increasing_run_length #(
    parameter int MAX_ITEMS  = lirl_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS = lirl_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lirl_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] box_size
    input  logic                           s_tlast,   // is_last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lirl_pkg::M_TDATA_W-1:0] m_tdata,   // [10:0] run_length, rest zero
    output logic [lirl_pkg::M_TUSER_W-1:0] m_tuser    // [0] overflow
);
    import lirl_pkg::*;

    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int ITEMS_W = $clog2(MAX_ITEMS + 2);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ITEMS_W-1:0]    items_reg, items_next;
    logic [ITEMS_W-1:0]    drain_cnt_reg, drain_cnt_next;
    logic                  drain_reg, drain_next;
    logic                  out_vld_reg, out_vld_next;
    logic [RUN_W-1:0]      run_reg, run_next;
    logic                  ovf_reg, ovf_next;

    logic                  s_xfer;
    logic                  room;
    logic                  settled;
    logic                  done;
    logic [31:0]           box_ext;
    logic [31:0]           cnt_ext;

    logic                  link_vld [MAX_ITEMS];
    logic [VALUE_BITS-1:0] link_val [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]  append_vec;

    assign box_ext = 32'(s_tdata);
    assign cnt_ext = 32'(count_reg);

    assign s_tready = !drain_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign room     = (items_reg < ITEMS_W'(MAX_ITEMS));

    // value entering cell 0; values past the limit are dropped
    assign link_vld[0] = s_xfer && room;
    assign link_val[0] = box_ext[VALUE_BITS-1:0];

    generate
        for (genvar k = 0; k < MAX_ITEMS; k++)
        begin : g_cell
            if (k < MAX_ITEMS - 1)
            begin : g_mid
                lirl_cell #(
                    .VALUE_BITS (VALUE_BITS),
                    .CNT_W      (CNT_W),
                    .IDX        (k)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .in_valid   (link_vld[k]),
                    .in_value   (link_val[k]),
                    .fill       (count_reg),
                    .pass_valid (link_vld[k+1]),
                    .pass_value (link_val[k+1]),
                    .append     (append_vec[k])
                );
            end
            else
            begin : g_end
                // a value passing the last cell has nowhere to go
                lirl_cell #(
                    .VALUE_BITS (VALUE_BITS),
                    .CNT_W      (CNT_W),
                    .IDX        (k)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .in_valid   (link_vld[k]),
                    .in_value   (link_val[k]),
                    .fill       (count_reg),
                    .pass_valid (),
                    .pass_value (),
                    .append     (append_vec[k])
                );
            end
        end
    endgenerate

    // last value sits at cell drain_cnt or has stopped; past the fill count
    // nothing can still be moving
    assign settled = drain_reg && (drain_cnt_reg > ITEMS_W'(count_reg));
    assign done    = settled && (!out_vld_reg || m_tready);

    always_comb
    begin
        count_next     = count_reg;
        items_next     = items_reg;
        drain_next     = drain_reg;
        drain_cnt_next = drain_cnt_reg;
        out_vld_next   = out_vld_reg;
        run_next       = run_reg;
        ovf_next       = ovf_reg;

        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        // at most one cell can append per cycle: the first open one
        if (|append_vec)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        if (s_xfer)
        begin
            items_next = room ? items_reg + ITEMS_W'(1) : ITEMS_W'(MAX_ITEMS + 1);
            if (s_tlast)
            begin
                drain_next     = 1'b1;
                drain_cnt_next = '0;
            end
        end

        if (drain_reg && !settled)
        begin
            drain_cnt_next = drain_cnt_reg + ITEMS_W'(1);
        end

        if (done)
        begin
            out_vld_next = 1'b1;
            run_next     = cnt_ext[RUN_W-1:0];
            ovf_next     = (items_reg > ITEMS_W'(MAX_ITEMS));
            count_next   = '0;
            items_next   = '0;
            drain_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            items_reg     <= '0;
            drain_reg     <= 1'b0;
            drain_cnt_reg <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            items_reg     <= items_next;
            drain_reg     <= drain_next;
            drain_cnt_reg <= drain_cnt_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
        ovf_reg <= ovf_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_TDATA_W'(run_reg);
    assign m_tuser  = M_TUSER_W'(ovf_reg);

endmodule

// ----- src/lirl_cell.sv -----
// One cell of the tail chain: holds the smallest tail for one run length and
// forwards values that are larger than its tail. No package dependency.
module lirl_cell #(
    parameter int VALUE_BITS = 16,
    parameter int CNT_W      = 11,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic [CNT_W-1:0]      fill,
    output logic                  pass_valid,
    output logic [VALUE_BITS-1:0] pass_value,
    output logic                  append
);

    logic                  slot_vld_reg;
    logic [VALUE_BITS-1:0] slot_val_reg;
    logic [VALUE_BITS-1:0] tail_reg;
    logic                  is_open;
    logic                  tail_ge;

    // cells at or beyond the fill count hold no tail yet
    assign is_open = (CNT_W'(IDX) >= fill);
    assign tail_ge = (tail_reg >= slot_val_reg);

    assign pass_valid = slot_vld_reg && !is_open && !tail_ge;
    assign pass_value = slot_val_reg;
    assign append     = slot_vld_reg && is_open;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= 1'b0;
        end
        else
        begin
            slot_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_val_reg <= in_value;
        if (slot_vld_reg && (is_open || tail_ge))
        begin
            tail_reg <= slot_val_reg;
        end
    end

endmodule

// ----- src/lirl_checker.sv -----
// Port-level checks for longest_increasing_run_length, bound to the top level.
// Depends on lirl_pkg.
module lirl_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lirl_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lirl_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [lirl_pkg::M_TUSER_W-1:0] m_tuser
);
    import lirl_pkg::*;

    // result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    // chain drains after the final transfer of a sequence
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken during drain");

    // any sequence has at least one value, and the length fits its field
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[RUN_W-1:0] != '0) && (m_tdata[M_TDATA_W-1:RUN_W] == '0)))
        else $error("run length out of range");

endmodule

bind longest_increasing_run_length lirl_checker u_lirl_checker (.*);
